>>> sv/sdss_pkg.sv
// shared constants for the depth stream snapshot sync core
// no dependencies; imported by sdss_diff_buf, depth_stream_snapshot_sync_core and its bench
package sdss_pkg;

   localparam int ID_BITS          = 64;
   localparam int TAG_PORT_BITS    = 16;
   localparam int KIND_BITS        = 2;
   localparam int BUFFER_DEPTH_DEF = 32;
   localparam int TAG_BITS_DEF     = 16;

   // input item function codes
   localparam logic FUNC_DIFF     = 1'b0;
   localparam logic FUNC_SNAPSHOT = 1'b1;

   // result kinds
   localparam logic [KIND_BITS-1:0] KIND_DIFF     = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_SNAPSHOT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_REQUEST  = 2'd2;

endpackage

>>> sv/sdss_diff_buf.sv
// pending diff buffer: one write port, one read port with registered read data
// depends on sdss_pkg
module sdss_diff_buf #(
   parameter int DEPTH = sdss_pkg::BUFFER_DEPTH_DEF,
   parameter int WIDTH = 2 * sdss_pkg::ID_BITS + sdss_pkg::TAG_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   import sdss_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/depth_stream_snapshot_sync_core.sv
// depth stream snapshot sync core: sequencer, shared span compare and result register
// depends on sdss_pkg and sdss_diff_buf
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_stall | func, first_id, last_id, snapshot_last_id, tag
//   rsp_    | out       | rsp_valid/rsp_stall | kind, ids, tag, last_of_run, flags
//
// a live diff, a diff buffered before the snapshot, or an ignored snapshot is handled in idle.
// a search reads, then compares each buffered entry in turn (one read port, registered data);
// a search started by a snapshot then forwards it, and a match flushes the matching entry
// and every later buffered diff, one at a time.
// synchronous reset clears stage, sequencer, fill count, overflow flag and result valid; buffer is not cleared.
// req_stall is high during reset; req is taken only when idle and the result slot frees.
// a stalled result holds the sequencer in idle and at its output phases, not in a search.
module depth_stream_snapshot_sync_core #(
   parameter int BUFFER_DEPTH = sdss_pkg::BUFFER_DEPTH_DEF,
   parameter int TAG_BITS     = sdss_pkg::TAG_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [sdss_pkg::ID_BITS-1:0]       req_first_id,
   input  logic [sdss_pkg::ID_BITS-1:0]       req_last_id,
   input  logic [sdss_pkg::ID_BITS-1:0]       req_snapshot_last_id,
   input  logic [sdss_pkg::TAG_PORT_BITS-1:0] req_payload_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sdss_pkg::KIND_BITS-1:0]     rsp_out_kind,
   output logic [sdss_pkg::ID_BITS-1:0]       rsp_out_first_id,
   output logic [sdss_pkg::ID_BITS-1:0]       rsp_out_last_id,
   output logic [sdss_pkg::TAG_PORT_BITS-1:0] rsp_out_tag,
   output logic                               rsp_last_of_run,
   output logic                               rsp_gap_error,
   output logic                               rsp_stream_live,
   output logic                               rsp_overflow
);
   import sdss_pkg::*;

   localparam int AddrBits  = $clog2(BUFFER_DEPTH);
   localparam int CntBits   = $clog2(BUFFER_DEPTH + 1);
   localparam int StTagBits = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;
   localparam int EntryBits = 2 * ID_BITS + StTagBits;

   typedef enum logic [1:0] {
      ST_WAIT,
      ST_REQ,
      ST_SEARCH,
      ST_LIVE
   } stage_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SRCH_RD,
      PH_SRCH_CMP,
      PH_SNAP_OUT,
      PH_FL_RD,
      PH_FL_OUT
   } phase_type;

   stage_type               stage_ff, stage_in;
   phase_type               phase_ff, phase_in;
   logic [CntBits-1:0]      count_ff, count_in;
   logic [CntBits-1:0]      idx_ff, idx_in;
   logic [ID_BITS-1:0]      snap_id_ff, snap_id_in;
   logic [ID_BITS-1:0]      want_ff, want_in;
   logic [StTagBits-1:0]    snap_tag_ff, snap_tag_in;
   logic                    is_snap_ff, is_snap_in;
   logic                    found_ff, found_in;
   logic [ID_BITS-1:0]      prev_ff, prev_in;
   logic                    ovf_ff, ovf_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [ID_BITS-1:0]       rsp_first_ff, rsp_first_in;
   logic [ID_BITS-1:0]       rsp_last_ff, rsp_last_in;
   logic [TAG_PORT_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic                     rsp_lor_ff, rsp_lor_in;
   logic                     rsp_gap_ff, rsp_gap_in;
   logic                     rsp_live_ff, rsp_live_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;

   logic                 mem_wr_en;
   logic [AddrBits-1:0]  mem_wr_addr;
   logic [EntryBits-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AddrBits-1:0]  mem_rd_addr;
   logic [EntryBits-1:0] mem_rd_data;

   logic                 out_free;
   logic                 req_take;
   logic [StTagBits-1:0] req_tag_st;
   logic [ID_BITS-1:0]   rd_first;
   logic [ID_BITS-1:0]   rd_last;
   logic [StTagBits-1:0] rd_tag;
   logic                 span_hit;
   logic                 buf_full;
   logic [CntBits-1:0]   idx_next;

   sdss_diff_buf #(
      .DEPTH (BUFFER_DEPTH),
      .WIDTH (EntryBits)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = reset || !((phase_ff == PH_IDLE) && out_free);
   assign req_take   = req_valid && !req_stall;
   assign req_tag_st = req_payload_tag[StTagBits-1:0];

   assign rd_first = mem_rd_data[EntryBits-1 -: ID_BITS];
   assign rd_last  = mem_rd_data[EntryBits-1-ID_BITS -: ID_BITS];
   assign rd_tag   = mem_rd_data[StTagBits-1:0];

   // shared span compare, used once per examined entry
   assign span_hit = (rd_first <= want_ff) && (want_ff <= rd_last);
   assign buf_full = (count_ff >= CntBits'(BUFFER_DEPTH));
   assign idx_next = idx_ff + CntBits'(1);

   always_comb begin
      stage_in     = stage_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      snap_id_in   = snap_id_ff;
      want_in      = want_ff;
      snap_tag_in  = snap_tag_ff;
      is_snap_in   = is_snap_ff;
      found_in     = found_ff;
      prev_in      = prev_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_first_in = rsp_first_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_lor_in   = rsp_lor_ff;
      rsp_gap_in   = rsp_gap_ff;
      rsp_live_in  = rsp_live_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = count_ff[AddrBits-1:0];
      mem_wr_data  = {req_first_id, req_last_id, req_tag_st};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = idx_ff[AddrBits-1:0];

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_take) begin
               if (req_func == FUNC_DIFF) begin
                  if (stage_ff == ST_LIVE) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_DIFF;
                     rsp_first_in = req_first_id;
                     rsp_last_in  = req_last_id;
                     rsp_tag_in   = TAG_PORT_BITS'(req_tag_st);
                     rsp_lor_in   = 1'b1;
                     rsp_gap_in   = (prev_ff + ID_BITS'(1)) != req_first_id;
                     rsp_live_in  = 1'b1;
                     rsp_ovf_in   = ovf_ff;
                     prev_in      = req_last_id;
                  end else begin
                     if (buf_full) begin
                        ovf_in = 1'b1;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = count_ff + CntBits'(1);
                     end
                     if (stage_ff == ST_WAIT) begin
                        stage_in     = ST_REQ;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_REQUEST;
                        rsp_first_in = '0;
                        rsp_last_in  = '0;
                        rsp_tag_in   = '0;
                        rsp_lor_in   = 1'b1;
                        rsp_gap_in   = 1'b0;
                        rsp_live_in  = 1'b0;
                        rsp_ovf_in   = ovf_ff;
                     end else if (stage_ff == ST_SEARCH) begin
                        is_snap_in = 1'b0;
                        idx_in     = '0;
                        phase_in   = PH_SRCH_RD;
                     end
                  end
               end else if (stage_ff == ST_REQ) begin
                  stage_in    = ST_SEARCH;
                  snap_id_in  = req_snapshot_last_id;
                  want_in     = req_snapshot_last_id + ID_BITS'(1);
                  snap_tag_in = req_tag_st;
                  is_snap_in  = 1'b1;
                  idx_in      = '0;
                  phase_in    = PH_SRCH_RD;
               end
            end
         end
         PH_SRCH_RD: begin
            if (idx_ff == count_ff) begin
               // no entry spans the wanted id
               found_in = 1'b0;
               phase_in = is_snap_ff ? PH_SNAP_OUT : PH_IDLE;
            end else begin
               mem_rd_en = 1'b1;
               phase_in  = PH_SRCH_CMP;
            end
         end
         PH_SRCH_CMP: begin
            if (span_hit) begin
               found_in = 1'b1;
               phase_in = is_snap_ff ? PH_SNAP_OUT : PH_FL_RD;
            end else begin
               idx_in   = idx_next;
               phase_in = PH_SRCH_RD;
            end
         end
         PH_SNAP_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SNAPSHOT;
               rsp_first_in = '0;
               rsp_last_in  = snap_id_ff;
               rsp_tag_in   = TAG_PORT_BITS'(snap_tag_ff);
               rsp_lor_in   = !found_ff;
               rsp_gap_in   = 1'b0;
               rsp_live_in  = found_ff;
               rsp_ovf_in   = ovf_ff;
               phase_in     = found_ff ? PH_FL_RD : PH_IDLE;
            end
         end
         PH_FL_RD: begin
            mem_rd_en = 1'b1;
            phase_in  = PH_FL_OUT;
         end
         PH_FL_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DIFF;
               rsp_first_in = rd_first;
               rsp_last_in  = rd_last;
               rsp_tag_in   = TAG_PORT_BITS'(rd_tag);
               rsp_lor_in   = (idx_next == count_ff);
               rsp_gap_in   = 1'b0;
               rsp_live_in  = 1'b1;
               rsp_ovf_in   = ovf_ff;
               prev_in      = rd_last;
               if (idx_next == count_ff) begin
                  count_in = '0;
                  stage_in = ST_LIVE;
                  phase_in = PH_IDLE;
               end else begin
                  idx_in   = idx_next;
                  phase_in = PH_FL_RD;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= ST_WAIT;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      snap_id_ff   <= snap_id_in;
      want_ff      <= want_in;
      snap_tag_ff  <= snap_tag_in;
      is_snap_ff   <= is_snap_in;
      found_ff     <= found_in;
      prev_ff      <= prev_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_first_ff <= rsp_first_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_lor_ff   <= rsp_lor_in;
      rsp_gap_ff   <= rsp_gap_in;
      rsp_live_ff  <= rsp_live_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_kind     = rsp_kind_ff;
   assign rsp_out_first_id = rsp_first_ff;
   assign rsp_out_last_id  = rsp_last_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_last_of_run  = rsp_lor_ff;
   assign rsp_gap_error    = rsp_gap_ff;
   assign rsp_stream_live  = rsp_live_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(BUFFER_DEPTH))
      else $error("pending count beyond buffer depth");

   a_live_empty: assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_LIVE |-> count_ff == '0)
      else $error("buffer not empty while live");

   a_diff_is_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_DIFF |-> rsp_live_ff)
      else $error("diff item forwarded before the stream went live");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

endmodule

>>> bench/depth_stream_snapshot_sync_core_tb.sv
// self-checking bench for depth_stream_snapshot_sync_core: queue-fed driver, clocked monitor
// and an in-bench tracker of the sync sequencer; depends on sdss_pkg and the core rtl only
// covers ignored snapshots, request, buffering, search, flush, overflow, live gaps and id wrap
module depth_stream_snapshot_sync_core_tb;
   import sdss_pkg::*;

   localparam int          BUF_DEPTH = BUFFER_DEPTH_DEF;
   localparam int          TAG_W     = TAG_BITS_DEF;
   localparam logic [63:0] TAG_MASK  = (64'd1 << TAG_W) - 64'd1;
   localparam int          LIMIT     = 500000;
   localparam int          SETTLE    = 200;
   localparam int          HOLD_AT   = 60;
   localparam int          LONG_HOLD = 150;
   localparam int          N_RANDOM  = 200;

   typedef enum logic [1:0] {SYNC_WAIT, SYNC_REQUESTED, SYNC_SEARCH, SYNC_LIVE} sync_stage_type;

   typedef struct {
      logic        func;
      logic [63:0] first_id;
      logic [63:0] last_id;
      logic [63:0] snap_id;
      logic [15:0] tag;
   } upd_type;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] first_id;
      logic [63:0] last_id;
      logic [15:0] tag;
      logic        last_of_run;
      logic        gap;
      logic        live;
      logic        ovf;
   } out_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_func = FUNC_DIFF;
   logic [ID_BITS-1:0]         req_first_id = '0;
   logic [ID_BITS-1:0]         req_last_id = '0;
   logic [ID_BITS-1:0]         req_snapshot_last_id = '0;
   logic [TAG_PORT_BITS-1:0]   req_payload_tag = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]       rsp_out_kind;
   logic [ID_BITS-1:0]         rsp_out_first_id;
   logic [ID_BITS-1:0]         rsp_out_last_id;
   logic [TAG_PORT_BITS-1:0]   rsp_out_tag;
   logic                       rsp_last_of_run;
   logic                       rsp_gap_error;
   logic                       rsp_stream_live;
   logic                       rsp_overflow;

   depth_stream_snapshot_sync_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_first_id         (req_first_id),
      .req_last_id          (req_last_id),
      .req_snapshot_last_id (req_snapshot_last_id),
      .req_payload_tag      (req_payload_tag),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_kind         (rsp_out_kind),
      .rsp_out_first_id     (rsp_out_first_id),
      .rsp_out_last_id      (rsp_out_last_id),
      .rsp_out_tag          (rsp_out_tag),
      .rsp_last_of_run      (rsp_last_of_run),
      .rsp_gap_error        (rsp_gap_error),
      .rsp_stream_live      (rsp_stream_live),
      .rsp_overflow         (rsp_overflow)
   );

   // tracked copy of the sequencer state
   sync_stage_type sync_stage = SYNC_WAIT;
   logic [63:0] stash_first [BUF_DEPTH];
   logic [63:0] stash_last [BUF_DEPTH];
   logic [15:0] stash_tag [BUF_DEPTH];
   int          stash_count = 0;
   logic [63:0] snap_id_held = '0;
   logic [63:0] prev_last = '0;
   logic        sticky_ovf = 1'b0;

   upd_type     feed [$];
   out_type     run_out [$];
   out_type     predicted_out [$];
   upd_type     tx_cur;

   int          items_total = 0;
   int          items_sent = 0;
   int          results_seen = 0;
   int          gaps_seen = 0;
   int          most_per_item = 0;
   int          mismatches = 0;
   int          tx_wait = 0;
   int          rx_wait = 0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;
   int unsigned cycle_count = 0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [15:0] rand16();
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic upd_type diff_item(logic [63:0] f, logic [63:0] l, logic [15:0] t);
      upd_type u;
      u.func = FUNC_DIFF;
      u.first_id = f;
      u.last_id = l;
      u.snap_id = rand64();
      u.tag = t;
      return u;
   endfunction

   function automatic upd_type snap_item(logic [63:0] s, logic [15:0] t);
      upd_type u;
      u.func = FUNC_SNAPSHOT;
      u.first_id = rand64();
      u.last_id = rand64();
      u.snap_id = s;
      u.tag = t;
      return u;
   endfunction

   function automatic out_type make_out(logic [1:0] kind, logic [63:0] fid, logic [63:0] lid,
                                        logic [15:0] tag, logic gap);
      out_type r;
      r.kind = kind;
      r.first_id = fid;
      r.last_id = lid;
      r.tag = tag & TAG_MASK[15:0];
      r.last_of_run = 1'b0;
      r.gap = gap;
      r.live = 1'b0;
      r.ovf = 1'b0;
      return r;
   endfunction

   task automatic stash_diff(input upd_type u);
      if (stash_count >= BUF_DEPTH) begin
         sticky_ovf = 1'b1;
      end else begin
         stash_first[stash_count] = u.first_id;
         stash_last[stash_count] = u.last_id;
         stash_tag[stash_count] = u.tag & TAG_MASK[15:0];
         stash_count++;
      end
   endtask

   // find the first stashed diff spanning snapshot id + 1, forward it and the rest
   task automatic search_and_flush();
      logic [63:0] target;
      int          hit;
      target = snap_id_held + 64'd1;
      hit = -1;
      for (int i = 0; i < stash_count; i++)
         if (hit < 0 && stash_first[i] <= target && target <= stash_last[i])
            hit = i;
      if (hit >= 0) begin
         for (int i = hit; i < stash_count; i++) begin
            run_out.push_back(make_out(KIND_DIFF, stash_first[i], stash_last[i],
                                       stash_tag[i], 1'b0));
            prev_last = stash_last[i];
         end
         stash_count = 0;
         sync_stage = SYNC_LIVE;
      end
   endtask

   task automatic sync_track(input upd_type u);
      run_out.delete();
      if (u.func == FUNC_DIFF) begin
         unique case (sync_stage)
            SYNC_WAIT: begin
               stash_diff(u);
               run_out.push_back(make_out(KIND_REQUEST, '0, '0, '0, 1'b0));
               sync_stage = SYNC_REQUESTED;
            end
            SYNC_REQUESTED: stash_diff(u);
            SYNC_SEARCH: begin
               stash_diff(u);
               search_and_flush();
            end
            default: begin
               run_out.push_back(make_out(KIND_DIFF, u.first_id, u.last_id, u.tag,
                                          (prev_last + 64'd1) != u.first_id));
               prev_last = u.last_id;
            end
         endcase
      end else if (sync_stage == SYNC_REQUESTED) begin
         snap_id_held = u.snap_id;
         run_out.push_back(make_out(KIND_SNAPSHOT, '0, u.snap_id, u.tag, 1'b0));
         sync_stage = SYNC_SEARCH;
         search_and_flush();
      end
      if (run_out.size() > most_per_item)
         most_per_item = run_out.size();
      foreach (run_out[i]) begin
         run_out[i].live = (sync_stage == SYNC_LIVE);
         run_out[i].ovf = sticky_ovf;
         run_out[i].last_of_run = (i == run_out.size() - 1);
         predicted_out.push_back(run_out[i]);
      end
   endtask

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // sender: one item per handshake, random gaps with calm stretches
   always @(posedge clock) begin : tx_side
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            sync_track(tx_cur);
            items_sent++;
            if ($urandom_range(0, 39) == 0)
               tx_calm = !tx_calm;
            tx_wait = tx_calm ? 0 : $urandom_range(0, 3);
         end
         if (!req_valid || !req_stall) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_valid <= 1'b0;
            end else if (feed.size() > 0) begin
               tx_cur = feed.pop_front();
               req_valid <= 1'b1;
               req_func <= tx_cur.func;
               req_first_id <= tx_cur.first_id;
               req_last_id <= tx_cur.last_id;
               req_snapshot_last_id <= tx_cur.snap_id;
               req_payload_tag <= tx_cur.tag;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result against the oldest prediction
   always @(posedge clock) begin : rx_side
      out_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_out.size() == 0) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("%0t: unexpected result, expected none, got kind %0d ids %h %h",
                           $time, rsp_out_kind, rsp_out_first_id, rsp_out_last_id);
            end else begin
               exp_r = predicted_out.pop_front();
               check_field("out_kind", exp_r.kind, rsp_out_kind);
               check_field("out_first_id", exp_r.first_id, rsp_out_first_id);
               check_field("out_last_id", exp_r.last_id, rsp_out_last_id);
               check_field("out_tag", exp_r.tag, rsp_out_tag);
               check_field("last_of_run", exp_r.last_of_run, rsp_last_of_run);
               check_field("gap_error", exp_r.gap, rsp_gap_error);
               check_field("stream_live", exp_r.live, rsp_stream_live);
               check_field("overflow", exp_r.ovf, rsp_overflow);
            end
            results_seen++;
            if (rsp_gap_error)
               gaps_seen++;
            // one long hold so the core backs up into its input
            if (results_seen == HOLD_AT) begin
               rx_wait = LONG_HOLD;
            end else begin
               if ($urandom_range(0, 39) == 0)
                  rx_calm = !rx_calm;
               rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
            end
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_stall <= (rx_wait > 0);
      end
   end

   initial begin : stim
      logic [63:0] nxt;
      logic [63:0] f;
      logic [63:0] l;
      logic [63:0] gp;
      logic [63:0] want_id;
      logic [63:0] firsts [BUF_DEPTH];
      logic [63:0] lasts [BUF_DEPTH];
      int          m;
      int          r;
      bit          overflow_path;
      string       path_name;

      // start-up happens once per run: either an overflowing stash flushed by the
      // snapshot, or a search that finds nothing until a later diff spans the id
      overflow_path = $urandom_range(0, 1);
      feed.push_back(snap_item('1, rand16()));   // unrequested, before any diff
      if (overflow_path) begin
         path_name = "overflowing stash flushed by the snapshot";
         nxt = rand64() >> 1;
         for (int k = 0; k < BUF_DEPTH + 2; k++) begin
            f = nxt;
            l = nxt + $urandom_range(0, 7);
            if (k < BUF_DEPTH) begin
               firsts[k] = f;
               lasts[k] = l;
            end
            feed.push_back(diff_item(f, l, (k == 0) ? 16'hFFFF : (k == 1) ? 16'h0000 : rand16()));
            nxt = l + 64'd1;
         end
         m = $urandom_range(0, 1) ? 0 : $urandom_range(1, BUF_DEPTH - 1);
         want_id = firsts[m] + $urandom_range(0, 7 & (lasts[m] - firsts[m]));
         feed.push_back(snap_item(want_id - 64'd1, rand16()));
         gp = lasts[BUF_DEPTH - 1];
      end else begin
         path_name = "search without a match, then a late spanning diff";
         feed.push_back(diff_item(64'd1, 64'd5, 16'hFFFF));
         feed.push_back(diff_item(64'd6, 64'd10, 16'h0000));
         feed.push_back(diff_item(64'd11, 64'd20, rand16()));
         // snapshot id + 1 wraps to zero, nothing stashed spans it
         feed.push_back(snap_item('1, rand16()));
         feed.push_back(snap_item(rand64(), rand16()));   // ignored while searching
         feed.push_back(diff_item(64'd21, 64'd30, rand16()));
         feed.push_back(diff_item(64'd0, 64'd2, rand16()));
         gp = 64'd2;
      end

      // live edge cases: top of id space, wrap to zero, a gap, an ignored snapshot
      feed.push_back(diff_item(gp + 64'd1, '1, 16'hFFFF));
      feed.push_back(diff_item(64'd0, 64'd0, 16'h0000));
      feed.push_back(diff_item('1, 64'h8000_0000_0000_0000, rand16()));
      feed.push_back(snap_item(64'd0, rand16()));
      gp = 64'h8000_0000_0000_0000;

      // mostly contiguous runs, with jumps and stray snapshots mixed in
      repeat (N_RANDOM) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            f = gp + 64'd1;
            l = ($urandom_range(0, 15) == 0) ? rand64() : f + $urandom_range(0, 20);
            feed.push_back(diff_item(f, l, rand16()));
            gp = l;
         end else if (r < 88) begin
            l = rand64();
            feed.push_back(diff_item(rand64(), l, rand16()));
            gp = l;
         end else begin
            feed.push_back(snap_item(rand64(), rand16()));
         end
      end
      items_total = feed.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while ((items_sent < items_total || predicted_out.size() != 0) && cycle_count < LIMIT)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (cycle_count >= LIMIT) begin
         mismatches++;
         $display("%0t: timed out after %0d cycles, %0d of %0d items taken",
                  $time, cycle_count, items_sent, items_total);
      end
      if (predicted_out.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived, expected kind %0d, got nothing",
                  $time, predicted_out.size(), predicted_out[0].kind);
      end
      $display("start-up via %s; %0d items in, %0d results checked", path_name, items_sent,
               results_seen);
      $display("%0d gap flags seen, up to %0d results from one item, %0d mismatches",
               gaps_seen, most_per_item, mismatches);
      if (mismatches == 0)
         $display("depth_stream_snapshot_sync_core_tb: done, clean");
      else
         $display("depth_stream_snapshot_sync_core_tb: done, errors");
      $finish;
   end

endmodule

>>> depth_stream_snapshot_sync_core.f
sv/sdss_pkg.sv
sv/sdss_diff_buf.sv
sv/depth_stream_snapshot_sync_core.sv
bench/depth_stream_snapshot_sync_core_tb.sv
